[src/assert_macros.svh]
// Assertion macros for the top-level RTL file, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/icre_pkg.sv]
// Package with the constants and types of the replicated-edge convolution filter.
package icre_pkg;
  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int MaxKernel  = 5;
  localparam int CoefFrac   = 14;
  localparam int RowSlots   = MaxKernel + 1;
  localparam int CoefDepth  = MaxKernel * MaxKernel;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int SlotW      = $clog2(RowSlots);
  localparam int CoefIdxW   = $clog2(CoefDepth);
  localparam int SumW       = 32;
  localparam int SlotShift  = 14;
  localparam int SlotRecip  = (1 << SlotShift) / RowSlots + 1;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_DRAIN = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KERNEL = 2'd2;

  // One classified operation handed from the front to the back.
  typedef struct packed {
    logic              is_load;
    logic [CoefIdxW-1:0] load_idx;
    logic [15:0]       load_val;
    logic              is_write;
    logic [SlotW-1:0]  wr_slot;
    logic [ColW-1:0]   wr_col;
    logic [7:0]        wr_pix;
    logic              is_out;
    logic [10:0]       out_row;
    logic [10:0]       out_col;
    logic              last;
    logic [10:0]       w;
    logic [10:0]       h;
    logic [2:0]        k;
  } op_t;

  // Line-store slot of a row: the row modulo RowSlots by reciprocal
  // multiplication, exact for every row below 1024.
  function automatic logic [SlotW-1:0] row_slot(input logic [10:0] row);
    logic [24:0] prod;
    logic [10:0] quo;
    logic [10:0] rem;
    prod = 25'(row) * 25'(SlotRecip);
    quo  = prod[SlotShift +: 11];
    rem  = row - 11'(quo * 11'(RowSlots));
    return rem[SlotW-1:0];
  endfunction
endpackage

[src/icre_front.sv]
// Front end: tracks input and output positions and classifies every item.
module icre_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_take,
  input  logic [1:0]         in_action,
  input  logic [5:0]         in_coef_index,
  input  logic [15:0]        in_coef_value,
  input  logic [7:0]         in_pixel_in,
  input  logic [10:0]        cfg_width,
  input  logic [10:0]        cfg_height,
  input  logic [2:0]         cfg_kernel,
  output logic               op_valid,
  output icre_pkg::op_t      op
);
  import icre_pkg::*;

  logic [10:0] in_row_r, in_col_r, out_row_r, out_col_r;
  logic [10:0] in_row_nxt, in_col_nxt, out_row_nxt, out_col_nxt;
  logic [10:0] w, h, half, ocol, orow, nr, nc;
  logic [2:0]  k;
  logic [21:0] need, recv;
  logic        ready_out;

  always_comb begin
    w = (cfg_width == 11'd0) ? 11'd1 :
        (cfg_width > 11'(MaxWidth)) ? 11'(MaxWidth) : cfg_width;
    h = (cfg_height == 11'd0) ? 11'd1 :
        (cfg_height > 11'(MaxHeight)) ? 11'(MaxHeight) : cfg_height;
    k = (cfg_kernel == 3'd0) ? 3'd1 : cfg_kernel[0] ? cfg_kernel : cfg_kernel - 3'd1;
    if (k > 3'(MaxKernel)) k = 3'(MaxKernel | 1) - ((MaxKernel % 2 == 0) ? 3'd2 : 3'd0);
    half = {9'd0, k[2:1]};
  end

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    op = '0;
    op.w = w; op.h = h; op.k = k;
    op.is_load  = in_action == ACT_LOAD && in_coef_index < 6'(CoefDepth);
    op.load_idx = CoefIdxW'(in_coef_index);
    op.load_val = in_coef_value;
    op.wr_pix   = in_pixel_in;
    orow = out_row_r;
    ocol = out_col_r;
    nr = '0; nc = '0; need = '0; recv = '0; ready_out = 1'b0;
    if (in_action == ACT_PIXEL || in_action == ACT_DRAIN) begin
      if (out_row_r >= h) begin
        in_row_nxt = '0; in_col_nxt = '0; out_row_nxt = '0; out_col_nxt = '0;
      end else begin
        if (in_action == ACT_PIXEL && in_row_r < h) begin
          op.is_write = 1'b1;
          op.wr_slot  = row_slot(in_row_r);
          op.wr_col   = ColW'((in_col_r < w) ? in_col_r : w - 11'd1);
          in_col_nxt  = in_col_r + 11'd1;
          if (in_col_nxt >= w) begin
            in_col_nxt = '0;
            in_row_nxt = in_row_r + 11'd1;
          end
        end
        if (ocol >= w) begin
          ocol = '0;
          orow = orow + 11'd1;
        end
        out_row_nxt = orow;
        out_col_nxt = ocol;
        if (orow >= h) begin
          in_row_nxt = '0; in_col_nxt = '0; out_row_nxt = '0; out_col_nxt = '0;
        end else begin
          nr = (orow + half < h - 11'd1) ? orow + half : h - 11'd1;
          nc = (ocol + half < w - 11'd1) ? ocol + half : w - 11'd1;
          need = 22'(nr) * 22'(w) + 22'(nc);
          recv = 22'(in_row_nxt) * 22'(w) + 22'((in_col_nxt < w) ? in_col_nxt : w);
          ready_out = (in_row_nxt >= h) || (recv > need);
          if (ready_out) begin
            op.is_out  = 1'b1;
            op.out_row = orow;
            op.out_col = ocol;
            op.last    = (orow == h - 11'd1) && (ocol == w - 11'd1);
            if (op.last) begin
              in_row_nxt = '0; in_col_nxt = '0; out_row_nxt = '0; out_col_nxt = '0;
            end else begin
              out_col_nxt = ocol + 11'd1;
            end
          end
        end
      end
    end
  end

  assign op_valid = in_take && (op.is_load || op.is_write || op.is_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
    end else if (in_take) begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end
endmodule

[src/icre_opq.sv]
// Short queue of classified operations between the front and the back.
module icre_opq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  icre_pkg::op_t wr_op,
  output logic          full,
  input  logic          rd_en,
  output logic          nonempty,
  output icre_pkg::op_t rd_op
);
  import icre_pkg::*;
  localparam int Depth = 4;
  op_t         mem_r [Depth];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;

  assign full     = cnt_r == 3'(Depth);
  assign nonempty = cnt_r != 3'd0;
  assign rd_op    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr_en) - 3'(rd_en);
    end
  end
endmodule

[src/icre_back.sv]
// Back end: applies writes and computes each output window one tap per cycle.
module icre_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_nonempty,
  input  icre_pkg::op_t op,
  output logic          op_pop,
  output logic          res_valid,
  output logic [7:0]    res_pixel,
  output logic          res_last,
  input  logic          res_take
);
  import icre_pkg::*;

  logic [15:0] coef_r [CoefDepth];
  logic [7:0]  line_r [RowSlots*MaxWidth];
  logic        busy_r;
  logic [2:0]  dr_r, dc_r;
  logic [2:0]  dr_nxt, dc_nxt;
  op_t         cur_r;
  logic signed [SumW-1:0] acc_r;
  logic        tap_v_r, tap_end_r;
  logic [7:0]  pix_r;
  logic signed [15:0] cf_r;
  logic signed [SumW-1:0] prod_r;
  logic        prod_v_r, prod_end_r;
  logic        fin_r;
  logic        hold_v_r, hold_last_r;
  logic [7:0]  hold_pix_r;
  logic        spare_v_r, spare_last_r;
  logic [7:0]  spare_pix_r;
  logic [11:0] rr, cc;
  logic [10:0] rc, ccl;
  logic [2:0]  half;
  logic        tap_last, start, can_start;
  logic [SumW-1:0] shifted;
  logic [7:0]  fin_pix;

  assign half = {1'b0, cur_r.k[2:1]};
  assign tap_last = (dr_r == cur_r.k - 3'd1) && (dc_r == cur_r.k - 3'd1);
  // A new window may start while one result waits in the hold register, since
  // the spare register behind it can take the next one.
  assign can_start = !busy_r && !tap_v_r && !prod_v_r && !fin_r && !spare_v_r;
  // Loads and line writes wait while a window is being read.
  assign start = op_nonempty && (op.is_out ? can_start : !busy_r);
  assign op_pop = start;

  always_comb begin
    rr  = 12'(cur_r.out_row) + 12'(dr_r) - 12'(half);
    cc  = 12'(cur_r.out_col) + 12'(dc_r) - 12'(half);
    rc  = rr[11] ? 11'd0 : (rr[10:0] > cur_r.h - 11'd1) ? cur_r.h - 11'd1 : rr[10:0];
    ccl = cc[11] ? 11'd0 : (cc[10:0] > cur_r.w - 11'd1) ? cur_r.w - 11'd1 : cc[10:0];
    dc_nxt = dc_r + 3'd1;
    dr_nxt = dr_r;
    if (dc_nxt == cur_r.k) begin
      dc_nxt = '0;
      dr_nxt = dr_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start && op.is_load) coef_r[op.load_idx] <= op.load_val;
    if (start && op.is_write) line_r[{op.wr_slot, op.wr_col}] <= op.wr_pix;
    pix_r <= line_r[{row_slot(rc), ColW'(ccl)}];
    cf_r  <= coef_r[CoefIdxW'(dr_r * cur_r.k + dc_r)];
    prod_r <= SumW'($signed(cf_r) * $signed({1'b0, pix_r}));
    if (start && op.is_out) cur_r <= op;
  end

  assign shifted = SumW'(acc_r >>> CoefFrac);
  assign fin_pix = acc_r[SumW-1] ? 8'd0 :
                   (shifted > SumW'(255)) ? 8'd255 : shifted[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; dr_r <= '0; dc_r <= '0; tap_v_r <= 1'b0; tap_end_r <= 1'b0;
      prod_v_r <= 1'b0; prod_end_r <= 1'b0; fin_r <= 1'b0; hold_v_r <= 1'b0;
      acc_r <= '0; hold_last_r <= 1'b0; hold_pix_r <= '0;
      spare_v_r <= 1'b0; spare_last_r <= 1'b0; spare_pix_r <= '0;
    end else begin
      tap_v_r <= busy_r;
      tap_end_r <= busy_r && tap_last;
      prod_v_r <= tap_v_r;
      prod_end_r <= tap_end_r;
      fin_r <= prod_v_r && prod_end_r;
      if (start && op.is_out) begin
        busy_r <= 1'b1; dr_r <= '0; dc_r <= '0; acc_r <= '0;
      end else if (busy_r) begin
        dr_r <= dr_nxt; dc_r <= dc_nxt;
        if (tap_last) busy_r <= 1'b0;
      end
      if (prod_v_r) acc_r <= acc_r + prod_r;
      if (fin_r) begin
        if (!hold_v_r || res_take) begin
          hold_v_r    <= 1'b1;
          hold_last_r <= cur_r.last;
          hold_pix_r  <= fin_pix;
        end else begin
          spare_v_r    <= 1'b1;
          spare_last_r <= cur_r.last;
          spare_pix_r  <= fin_pix;
        end
      end else if (res_take && hold_v_r) begin
        if (spare_v_r) begin
          hold_last_r <= spare_last_r;
          hold_pix_r  <= spare_pix_r;
          spare_v_r   <= 1'b0;
        end else begin
          hold_v_r <= 1'b0;
        end
      end
    end
  end

  assign res_valid = hold_v_r;
  assign res_pixel = hold_pix_r;
  assign res_last  = hold_last_r;
endmodule

[src/image_convolution_replicate_edge_top.sv]
// Top level of the streaming convolution filter with replicated image borders.
// Usage: items enter through push/full; action selects a coefficient load, a
// pixel or a drain tick. Loads never yield results on their own; a
// pixel or drain yields one filtered pixel once its whole window has arrived.
// Results leave through empty/pop; frame_done marks the last pixel of a frame.
// The front stage classifies each item in its accept cycle and posts the work
// to a four-entry queue, so input is taken every cycle while that queue has room.
// The back stage applies loads and line writes one per cycle, but holds them
// while a window is being read so that the window sees the data of its own item.
// An output pixel walks its k*k window one tap per cycle through a single
// multiplier, and no new window starts before its taps have left the tap,
// product and finish registers; this tap loop sets the sustained output rate.
// A result goes from the queue through tap, product, sum and hold registers.
// Reset clears positions, queue and result registers; the coefficient table and
// line store keep whatever they hold. Configuration registers reset to 64, 64, 3.
// When the receiver stalls, the finished result waits in its register and one
// more result may finish into a spare register behind it; then the back stage
// stops, the queue fills, and full is raised; no item is lost.
// Configuration must be written only while the block is idle; the block does not enforce it.
module image_convolution_replicate_edge_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic [7:0]  in_pixel_in,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_pixel_out,
  output logic        out_frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import icre_pkg::*;
`include "assert_macros.svh"

  logic [10:0] width_r, height_r;
  logic [2:0]  kernel_r;
  logic        in_take, op_valid, q_full, q_ne, q_pop, res_valid;
  op_t         f_op, b_op;

  // Configuration is always accepted.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd64; height_r <= 11'd64; kernel_r <= 3'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_KERNEL: kernel_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign full    = q_full;
  assign in_take = push && !q_full;

  icre_front u_front (
    .clk, .rst_n, .in_take, .in_action, .in_coef_index,
    .in_coef_value(in_coef_value), .in_pixel_in,
    .cfg_width(width_r), .cfg_height(height_r), .cfg_kernel(kernel_r),
    .op_valid, .op(f_op)
  );

  icre_opq u_q (
    .clk, .rst_n, .wr_en(op_valid), .wr_op(f_op), .full(q_full),
    .rd_en(q_pop), .nonempty(q_ne), .rd_op(b_op)
  );

  icre_back u_back (
    .clk, .rst_n, .op_nonempty(q_ne), .op(b_op), .op_pop(q_pop),
    .res_valid, .res_pixel(out_pixel_out), .res_last(out_frame_done),
    .res_take(pop)
  );

  assign empty = !res_valid;

  `CHK_IMPL(a_no_push_when_full, clk, rst_n, full, !in_take, "item taken while full")
  `CHK_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(out_pixel_out),
            "waiting result changed")
endmodule

[test/tb.sv]
// Self-checking testbench for the replicated-edge convolution filter top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import icre_pkg::*;

  // Action code that the block ignores.
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Tracks coefficients, line rows and frame positions, and predicts each filtered pixel.
  class pixel_filter_tracker;
    typedef struct {
      logic [7:0] pix;
      logic       done;
    } filtered_t;

    logic [15:0]  coef_mem [CoefDepth];
    byte unsigned line_mem [RowSlots*MaxWidth];
    int unsigned  row_in, col_in, row_out, col_out;
    logic [10:0]  reg_w, reg_h;
    logic [2:0]   reg_k;
    filtered_t    expected_pixels [$];
    int           mismatches, pixels_checked, frames_closed;

    function new();
      reg_w = 64;
      reg_h = 64;
      reg_k = 3;
    endfunction

    function void set_reg(logic [1:0] idx, logic [10:0] data);
      case (idx)
        CFG_WIDTH:  reg_w = data;
        CFG_HEIGHT: reg_h = data;
        CFG_KERNEL: reg_k = data[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_w();
      int unsigned w;
      w = 32'(reg_w);
      if (w == 0) w = 1;
      if (w > MaxWidth) w = MaxWidth;
      return w;
    endfunction

    function int unsigned eff_h();
      int unsigned h;
      h = 32'(reg_h);
      if (h == 0) h = 1;
      if (h > MaxHeight) h = MaxHeight;
      return h;
    endfunction

    function int unsigned eff_k();
      int unsigned k;
      k = 32'(reg_k);
      if (k == 0) k = 1;
      if (k % 2 == 0) k--;
      if (k > MaxKernel) k = MaxKernel;
      if (k % 2 == 0) k--;
      if (k == 0) k = 1;
      return k;
    endfunction

    function void clear_pos();
      row_in = 0;
      col_in = 0;
      row_out = 0;
      col_out = 0;
    endfunction

    function bit busy();
      return (row_in | col_in | row_out | col_out) != 0;
    endfunction

    // Floored, saturated window sum at the current output position.
    function logic [7:0] window_sum(int w, int h, int k);
      longint sum, cv;
      int r, c, half;
      sum = 0;
      half = k / 2;
      for (int dr = 0; dr < k; dr++) begin
        r = int'(row_out) + dr - half;
        if (r < 0) r = 0;
        if (r > h - 1) r = h - 1;
        for (int dc = 0; dc < k; dc++) begin
          c = int'(col_out) + dc - half;
          if (c < 0) c = 0;
          if (c > w - 1) c = w - 1;
          cv = $signed(coef_mem[dr*k + dc]);
          sum += cv * longint'(line_mem[(r % RowSlots)*MaxWidth + c]);
        end
      end
      if (sum < 0) return 8'd0;
      sum = sum >>> CoefFrac;
      return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    function void note_item(logic [1:0] act, logic [5:0] idx, logic [15:0] val,
                            logic [7:0] pix);
      int unsigned w, h, k, half, nr, nc, c;
      longint unsigned need, recv;
      filtered_t res;
      w = eff_w();
      h = eff_h();
      k = eff_k();
      half = k / 2;
      if (act == ACT_LOAD) begin
        if (idx < CoefDepth) coef_mem[idx] = val;
        return;
      end
      if (act == ACT_NONE) return;
      if (row_out >= h) begin
        clear_pos();
        return;
      end
      if (act == ACT_PIXEL && row_in < h) begin
        c = (col_in < w) ? col_in : w - 1;
        line_mem[(row_in % RowSlots)*MaxWidth + c] = pix;
        col_in++;
        if (col_in >= w) begin
          col_in = 0;
          row_in++;
        end
      end
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
        if (row_out >= h) begin
          clear_pos();
          return;
        end
      end
      nr = (row_out + half < h - 1) ? row_out + half : h - 1;
      nc = (col_out + half < w - 1) ? col_out + half : w - 1;
      need = longint'(nr) * w + nc;
      recv = longint'(row_in) * w + ((col_in < w) ? col_in : w);
      if (!(row_in >= h || recv > need)) return;
      res.pix = window_sum(w, h, k);
      res.done = (row_out == h - 1 && col_out == w - 1);
      expected_pixels.push_back(res);
      if (res.done) begin
        clear_pos();
      end else begin
        col_out++;
        if (col_out >= w) begin
          col_out = 0;
          row_out++;
        end
      end
    endfunction

    function void check_result(logic [7:0] pix, logic done);
      filtered_t exp_res;
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected pixel %0d done %0b at %0t", pix, done, $realtime);
        return;
      end
      exp_res = expected_pixels.pop_front();
      if (exp_res.done) frames_closed++;
      if (pix !== exp_res.pix || done !== exp_res.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pixel exp %0d got %0d, frame_done exp %0b got %0b at %0t",
                   exp_res.pix, pix, exp_res.done, done, $realtime);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_action;
  logic [5:0]  in_coef_index;
  logic [15:0] in_coef_value;
  logic [7:0]  in_pixel_in;
  logic        empty;
  logic        pop;
  logic [7:0]  out_pixel_out;
  logic        out_frame_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  pixel_filter_tracker tracker = new();

  // Sender burst state and the receiver's long hold-off, counted down by the receiver.
  int burst_left = 0;
  int hold_left = 0;
  int items_sent = 0;

  image_convolution_replicate_edge_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_pixel_in   (in_pixel_in),
    .empty         (empty),
    .pop           (pop),
    .out_pixel_out (out_pixel_out),
    .out_frame_done(out_frame_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offers one item and holds it until the block takes it. Between bursts the
  // sender drops push for a random gap; inside a burst push stays high.
  task automatic send_item(input logic [1:0] act, input logic [5:0] idx,
                           input logic [15:0] val, input logic [7:0] pix);
    push <= 1'b1;
    in_action <= act;
    in_coef_index <= idx;
    in_coef_value <= val;
    in_pixel_in <= pix;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_item(act, idx, val, pix);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic send_pixel(input logic [7:0] pix);
    send_item(ACT_PIXEL, 6'($urandom_range(0, 63)), 16'($urandom), pix);
  endtask

  task automatic send_drain();
    send_item(ACT_DRAIN, 6'($urandom_range(0, 63)), 16'($urandom), 8'($urandom));
  endtask

  // Waits until every predicted pixel has come out, then lets the tap loop finish
  // any work that produces nothing, so that a register write finds the block idle.
  task automatic wait_quiet();
    push <= 1'b0;
    while (tracker.expected_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(input logic [10:0] w, input logic [10:0] h, input logic [2:0] k);
    wait_quiet();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_KERNEL, {8'd0, k});
  endtask

  // Reloads the whole kernel; the gentle set keeps most sums off the rails.
  task automatic load_kernel(input bit gentle);
    logic [15:0] v;
    for (int i = 0; i < CoefDepth; i++) begin
      v = gentle ? 16'($urandom_range(0, 6000) - 1500) : 16'($urandom);
      send_item(ACT_LOAD, 6'(i), v, 8'($urandom));
    end
  endtask

  // One frame: the pixels, sprinkled with noise, then drains until the
  // frame-done pixel has been predicted. A frame larger than max_pix is cut
  // short and left open, so the next shape carries its positions on.
  task automatic run_frame(input int noise_pct, input int max_pix);
    int n, r;
    bit whole;
    n = tracker.eff_w() * tracker.eff_h();
    whole = (n <= max_pix);
    if (!whole) n = max_pix;
    while (n > 0) begin
      r = $urandom_range(0, 99);
      if (r >= noise_pct) begin
        send_pixel(8'($urandom));
        n--;
      end else if (r % 3 == 0) begin
        send_item(ACT_LOAD, 6'($urandom_range(0, 63)), 16'($urandom), 8'($urandom));
      end else if (r % 3 == 1) begin
        send_item(ACT_NONE, 6'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        send_drain();
      end
    end
    while (whole && tracker.busy()) begin
      // A pixel after the frame is complete only acts as a drain.
      if ($urandom_range(0, 3) == 0) send_pixel(8'($urandom));
      else send_drain();
    end
  endtask

  // Receiver: pops on one of four patterns, picked anew at random, and honors
  // a long hold-off requested by the stimulus.
  initial begin
    int mode;
    int cnt;
    mode = 0;
    cnt = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (cnt % 4 == 0);
          default: pop <= ($urandom_range(0, 9) != 0);
        endcase
        cnt++;
        if (cnt % 50 == 0) mode = $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) tracker.check_result(out_pixel_out, out_frame_done);
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    push = 1'b0;
    in_action = ACT_NONE;
    in_coef_index = '0;
    in_coef_value = '0;
    in_pixel_in = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A drain and a pixel-free tick with nothing ready give
    // nothing, and out-of-range loads plus the unknown action are ignored.
    send_drain();
    send_item(ACT_NONE, 6'd63, 16'hFFFF, 8'hFF);
    send_item(ACT_LOAD, 6'd63, 16'h7FFF, 8'h00);
    send_item(ACT_LOAD, 6'd25, 16'h8000, 8'h00);
    // Kernel with both coefficient extremes at the corners of a 3x3 window.
    for (int i = 0; i < CoefDepth; i++)
      send_item(ACT_LOAD, 6'(i), (i == 0) ? 16'h7FFF : (i == 2) ? 16'h8000 : 16'h1000, 8'h00);
    set_shape(11'd3, 11'd2, 3'd3);
    for (int i = 0; i < 6; i++) send_pixel((i % 2) ? 8'hFF : 8'h00);
    while (tracker.busy()) send_drain();

    // Shrinking the height mid-frame makes the next tick restart the frame.
    set_shape(11'd4, 11'd4, 3'd3);
    for (int i = 0; i < 12; i++) send_pixel(8'($urandom));
    wait_quiet();
    write_reg(CFG_HEIGHT, 11'd1);
    send_drain();
    run_frame(0, 1 << 20);

    // Long receiver hold-off while the sender keeps pushing, so the input stalls.
    set_shape(11'd16, 11'd8, 3'd5);
    hold_left = 400;
    run_frame(5, 1 << 20);
    wait_quiet();

    // Random part, with the register extremes visited early on.
    for (int phase = 0; items_sent < 700 || phase < 8; phase++) begin
      case (phase)
        1: set_shape(11'd2047, 11'd1, 3'd7);
        3: set_shape(11'd0, 11'd2047, 3'd0);
        5: set_shape(11'd1024, 11'd2, 3'd4);
        7: set_shape(11'd1, 11'd1, 3'd6);
        default: set_shape(11'($urandom_range(1, 9)), 11'($urandom_range(1, 6)),
                           3'($urandom_range(0, 7)));
      endcase
      if ($urandom_range(0, 2) == 0) load_kernel($urandom_range(0, 3) != 0);
      run_frame($urandom_range(0, 15), 100);
      // Now and then the sender waits for every pending pixel before going on.
      if ($urandom_range(0, 3) == 0) wait_quiet();
    end

    wait_quiet();
    repeat (60) @(posedge clk);
    $display("Covered %0d items, %0d filtered pixels checked, %0d frames closed.",
             items_sent, tracker.pixels_checked, tracker.frames_closed);
    $display("Shapes from 1x1 up to 1024 wide or tall, all kernel sizes, %0d mismatches.",
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/icre_pkg.sv
src/icre_front.sv
src/icre_opq.sv
src/icre_back.sv
src/image_convolution_replicate_edge_top.sv
test/tb.sv
